### design/ptts_pkg.sv
package ptts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = 3;
  localparam int CNT_W      = 4;
  localparam int TIME_W     = 16;
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_DELETE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_IDLE  = 2'd0,
    STAT_READY = 2'd1,
    STAT_SUSP  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_SHIFT,
    ST_FLUSH
  } sched_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SLOT_W-1:0] slot_index;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] countdown;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } tbl_wr_t;

endpackage

### design/periodic_task_tick_scheduler.sv
// tick: visits min(count, 8) slots, one slot per cycle, by a shared
//   16-bit decrementer; each fired item leaves in the cycle after the next firing
//   slot is found, the final one (last set) in the first cycle busy is low
// create, suspend, resume: pass through APPLY; delete: SHIFT moves each slot above down
// a new item is taken in the first cycle busy is low; results cannot be stalled
// synchronous active-low reset: slots invalid and idle, active count 8, no results
module periodic_task_tick_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ptts_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ptts_pkg::out_item_t  out_item
);

  localparam int CW = ptts_pkg::CNT_W;
  localparam int SW = ptts_pkg::SLOT_W;
  localparam int TW = ptts_pkg::TIME_W;

  ptts_pkg::sched_state_t state_r, state_nxt;

  ptts_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       count_r, count_nxt;   // active task count
  logic [CW-1:0]       lim_r, lim_nxt;       // slots to visit, count clipped to table
  logic [CW-1:0]       ptr_r, ptr_nxt;       // slot being visited
  logic                pend_v_r, pend_v_nxt; // a fired slot waits for its last flag
  logic [SW-1:0]       pend_slot_r, pend_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptts_pkg::out_item_t out_item_r, out_item_nxt;

  ptts_pkg::tbl_wr_t     tbl_wr;
  logic [SW-1:0]         rd_idx;
  ptts_pkg::slot_entry_t rd_entry;

  logic          accept;
  logic          in_range;
  logic          cnt_zero;
  logic [TW-1:0] dec_opnd;
  logic [TW-1:0] dec_res;

  ptts_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  assign busy      = (state_r != ptts_pkg::ST_IDLE);
  assign accept    = start && (state_r == ptts_pkg::ST_IDLE);
  assign in_range  = (CW'(in_item.slot_index) < CW'(ptts_pkg::TASK_SLOTS));
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // visited slot comes from the pointer, single-slot ops address it directly
  assign rd_idx = (state_r == ptts_pkg::ST_APPLY) ? item_r.slot_index : ptr_r[SW-1:0];

  // shared decrementer: countdown - 1, or period - 1 on a reload (wraps mod 2^16)
  assign cnt_zero = (rd_entry.countdown == '0);
  assign dec_opnd = cnt_zero ? rd_entry.period : rd_entry.countdown;
  assign dec_res  = dec_opnd - TW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptts_pkg::ST_IDLE: begin
        if (start) begin
          if (in_item.operation == ptts_pkg::OP_TICK) begin
            state_nxt = ptts_pkg::ST_SCAN;
          end else if (in_item.operation == ptts_pkg::OP_DELETE && in_range) begin
            state_nxt = ptts_pkg::ST_SHIFT;
          end else begin
            state_nxt = ptts_pkg::ST_APPLY;
          end
        end
      end
      ptts_pkg::ST_APPLY: state_nxt = ptts_pkg::ST_IDLE;
      ptts_pkg::ST_SCAN: begin
        if (ptr_r >= lim_r) begin
          state_nxt = ptts_pkg::ST_FLUSH;
        end
      end
      ptts_pkg::ST_SHIFT: begin
        if (ptr_r >= lim_r) begin
          state_nxt = ptts_pkg::ST_IDLE;
        end
      end
      ptts_pkg::ST_FLUSH: state_nxt = ptts_pkg::ST_IDLE;
      default: state_nxt = ptts_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    count_nxt     = count_r;
    lim_nxt       = lim_r;
    ptr_nxt       = ptr_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    tbl_wr        = '0;
    tbl_wr.idx    = rd_idx;
    tbl_wr.entry  = rd_entry;

    unique case (state_r)
      ptts_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt   = in_item;
          pend_v_nxt = 1'b0;
          lim_nxt    = (count_r < CW'(ptts_pkg::TASK_SLOTS)) ?
                       count_r : CW'(ptts_pkg::TASK_SLOTS);
          ptr_nxt    = '0;
          if (in_item.operation == ptts_pkg::OP_DELETE && in_range) begin
            // moves start just above the deleted slot
            ptr_nxt = CW'(in_item.slot_index) + CW'(1);
            if (count_r != '0) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
      end

      ptts_pkg::ST_APPLY: begin
        if (CW'(item_r.slot_index) < CW'(ptts_pkg::TASK_SLOTS)) begin
          unique case (item_r.operation)
            ptts_pkg::OP_CREATE: begin
              tbl_wr.en              = 1'b1;
              tbl_wr.entry.valid     = 1'b1;
              tbl_wr.entry.status    = ptts_pkg::STAT_READY;
              tbl_wr.entry.period    = item_r.period;
              tbl_wr.entry.countdown = item_r.first_delay;
            end
            ptts_pkg::OP_SUSPEND: begin
              // suspends whatever the current status
              tbl_wr.en           = 1'b1;
              tbl_wr.entry.status = ptts_pkg::STAT_SUSP;
            end
            ptts_pkg::OP_RESUME: begin
              if (rd_entry.status == ptts_pkg::STAT_SUSP) begin
                tbl_wr.en           = 1'b1;
                tbl_wr.entry.status = ptts_pkg::STAT_READY;
              end
            end
            default: begin
              // unknown codes leave the table alone
            end
          endcase
        end
      end

      ptts_pkg::ST_SCAN: begin
        if (ptr_r < lim_r) begin
          if (rd_entry.valid && rd_entry.status == ptts_pkg::STAT_READY) begin
            tbl_wr.en              = 1'b1;
            tbl_wr.entry.countdown = dec_res;
            if (cnt_zero) begin
              // a newer firing proves the held one is not the last
              if (pend_v_r) begin
                out_valid_nxt           = 1'b1;
                out_item_nxt.fired_slot = pend_slot_r;
                out_item_nxt.last       = 1'b0;
              end
              pend_v_nxt    = 1'b1;
              pend_slot_nxt = ptr_r[SW-1:0];
            end
          end
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      ptts_pkg::ST_SHIFT: begin
        if (ptr_r < lim_r) begin
          tbl_wr.en  = 1'b1;
          tbl_wr.idx = SW'(ptr_r - CW'(1));
          ptr_nxt    = ptr_r + CW'(1);
        end
      end

      ptts_pkg::ST_FLUSH: begin
        // held firing is the final one of this tick
        out_valid_nxt           = pend_v_r;
        out_item_nxt.fired_slot = pend_slot_r;
        out_item_nxt.last       = 1'b1;
        pend_v_nxt              = 1'b0;
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptts_pkg::ST_IDLE;
      count_r     <= CW'(ptts_pkg::TASK_SLOTS);
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    lim_r       <= lim_nxt;
    ptr_r       <= ptr_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

### design/ptts_slot_table.sv
module ptts_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptts_pkg::tbl_wr_t             wr,
  input  logic [ptts_pkg::SLOT_W-1:0]   rd_idx,
  output ptts_pkg::slot_entry_t         rd_entry
);

  logic                          valid_r     [ptts_pkg::TASK_SLOTS];
  ptts_pkg::status_t             status_r    [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::TIME_W-1:0]   period_r    [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::TIME_W-1:0]   countdown_r [ptts_pkg::TASK_SLOTS];

  // valid and status come up cleared, timing fields only matter once created
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
        valid_r[i]  <= 1'b0;
        status_r[i] <= ptts_pkg::STAT_IDLE;
      end
    end else if (wr.en) begin
      valid_r[wr.idx]  <= wr.entry.valid;
      status_r[wr.idx] <= wr.entry.status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      period_r[wr.idx]    <= wr.entry.period;
      countdown_r[wr.idx] <= wr.entry.countdown;
    end
  end

  assign rd_entry.valid     = valid_r[rd_idx];
  assign rd_entry.status    = status_r[rd_idx];
  assign rd_entry.period    = period_r[rd_idx];
  assign rd_entry.countdown = countdown_r[rd_idx];

endmodule

### design/ptts_checker.sv
module ptts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input ptts_pkg::out_item_t  out_item
);

  // every accepted item raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // only the final item of a tick may show after the block went idle
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final fired item while idle");

  // the final item of a tick is never followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("fired item right after the final one");

  // reset leaves the block idle with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### test/periodic_task_tick_scheduler_tb.sv
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

  // operation codes the block must ignore
  localparam logic [ptts_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [ptts_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [ptts_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  // random part: main body, then a closing stretch that drains the table
  localparam int MAIN_ITEMS  = 115;
  localparam int DRAIN_ITEMS = 32;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ptts_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  ptts_pkg::out_item_t out_item;

  periodic_task_tick_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler shadow: slot table and active count as they stand after
  // every item accepted so far
  bit                          slot_on   [ptts_pkg::TASK_SLOTS];
  ptts_pkg::status_t           slot_stat [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::TIME_W-1:0] slot_per  [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::TIME_W-1:0] slot_left [ptts_pkg::TASK_SLOTS];
  logic [ptts_pkg::CNT_W-1:0]  sched_count;

  ptts_pkg::out_item_t tick_fires[$];  // firings of the latest shadow update
  ptts_pkg::out_item_t fire_q[$];      // fired items still to come out of the block

  int  errors = 0;
  bit  calm = 1'b0;          // no sender gaps while set

  typedef struct {
    ptts_pkg::in_item_t              cmd;
    bit                              typed;      // firing pattern written out by hand
    logic [ptts_pkg::TASK_SLOTS-1:0] fire_mask;  // slots expected to fire, in slot order
  } plan_row_t;

  plan_row_t plan[$];

  // advance the shadow by one item; firings land in tick_fires
  task automatic shadow_step(input ptts_pkg::in_item_t it);
    int                  lim;
    int                  idx;
    ptts_pkg::out_item_t f;
    tick_fires.delete();
    lim = (sched_count < ptts_pkg::TASK_SLOTS) ? int'(sched_count) : ptts_pkg::TASK_SLOTS;
    idx = it.slot_index;
    // every 3-bit index lies inside the 8-slot table, so no range guard
    case (it.operation)
      ptts_pkg::OP_TICK: begin
        for (int s = 0; s < lim; s++) begin
          if (slot_on[s] && slot_stat[s] == ptts_pkg::STAT_READY) begin
            if (slot_left[s] == '0) begin
              f.fired_slot = s[ptts_pkg::SLOT_W-1:0];
              f.last       = 1'b0;
              tick_fires.push_back(f);
              // period zero wraps to all ones
              slot_left[s] = slot_per[s] - 16'd1;
            end else begin
              slot_left[s] = slot_left[s] - 16'd1;
            end
          end
        end
        if (tick_fires.size() != 0)
          tick_fires[tick_fires.size()-1].last = 1'b1;
      end
      ptts_pkg::OP_CREATE: begin
        slot_on[idx]   = 1'b1;
        slot_per[idx]  = it.period;
        slot_left[idx] = it.first_delay;
        slot_stat[idx] = ptts_pkg::STAT_READY;
      end
      ptts_pkg::OP_SUSPEND: begin
        // applies even to an idle slot
        slot_stat[idx] = ptts_pkg::STAT_SUSP;
      end
      ptts_pkg::OP_RESUME: begin
        if (slot_stat[idx] == ptts_pkg::STAT_SUSP)
          slot_stat[idx] = ptts_pkg::STAT_READY;
      end
      ptts_pkg::OP_DELETE: begin
        // shift down inside the live range; the top source slot keeps its
        // contents, and the count drops even when nothing moves
        for (int s = idx + 1; s < lim; s++) begin
          slot_on[s-1]   = slot_on[s];
          slot_stat[s-1] = slot_stat[s];
          slot_per[s-1]  = slot_per[s];
          slot_left[s-1] = slot_left[s];
        end
        if (sched_count != '0)
          sched_count = sched_count - ptts_pkg::CNT_W'(1);
      end
      default: begin
        // unused codes change nothing
      end
    endcase
  endtask

  // one random command; deletes are rationed because the count never grows back
  function automatic ptts_pkg::in_item_t pick_command(input bit draining);
    ptts_pkg::in_item_t c;
    int                 r;
    c.slot_index  = ptts_pkg::SLOT_W'($urandom_range(0, ptts_pkg::TASK_SLOTS - 1));
    // mostly short periods and delays so slots keep firing
    c.period      = ($urandom_range(0, 3) != 0) ? ptts_pkg::TIME_W'($urandom_range(0, 5))
                                                : ptts_pkg::TIME_W'($urandom());
    c.first_delay = ($urandom_range(0, 3) != 0) ? ptts_pkg::TIME_W'($urandom_range(0, 4))
                                                : ptts_pkg::TIME_W'($urandom());
    r = $urandom_range(0, 99);
    if (draining) begin
      if (r < 40)      c.operation = ptts_pkg::OP_DELETE;
      else if (r < 70) c.operation = ptts_pkg::OP_TICK;
      else if (r < 90) c.operation = ptts_pkg::OP_CREATE;
      else             c.operation = ptts_pkg::OP_SUSPEND;
    end else if (r < 45) begin
      c.operation = ptts_pkg::OP_TICK;
    end else if (r < 67) begin
      c.operation = ptts_pkg::OP_CREATE;
    end else if (r < 78) begin
      c.operation = ptts_pkg::OP_SUSPEND;
    end else if (r < 90) begin
      c.operation = ptts_pkg::OP_RESUME;
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0:       c.operation = OP_RSVD5;
        1:       c.operation = OP_RSVD6;
        default: c.operation = OP_RSVD7;
      endcase
    end else begin
      c.operation = (sched_count > 4) ? ptts_pkg::OP_DELETE : ptts_pkg::OP_TICK;
    end
    return c;
  endfunction

  task automatic add_row(input logic [ptts_pkg::OP_W-1:0] op, input int idx,
                         input logic [ptts_pkg::TIME_W-1:0] per,
                         input logic [ptts_pkg::TIME_W-1:0] dly,
                         input bit typed, input logic [ptts_pkg::TASK_SLOTS-1:0] mask);
    plan_row_t row;
    row.cmd.operation   = op;
    row.cmd.slot_index  = ptts_pkg::SLOT_W'(idx);
    row.cmd.period      = per;
    row.cmd.first_delay = dly;
    row.typed           = typed;
    row.fire_mask       = mask;
    plan.push_back(row);
  endtask

  // hand one item to the block, called at a rising edge; returns at the
  // edge where it is taken, with the expected firings queued
  task automatic send_item(input ptts_pkg::in_item_t it, input bit typed,
                           input logic [ptts_pkg::TASK_SLOTS-1:0] mask);
    ptts_pkg::out_item_t f;
    if (!calm && $urandom_range(0, 3) == 0) begin
      start   <= 1'b0;
      in_item <= pick_command(1'b0);
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    shadow_step(it);
    if (typed) begin
      for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++) begin
        if (mask[s]) begin
          f.fired_slot = s[ptts_pkg::SLOT_W-1:0];
          f.last       = 1'b0;
          fire_q.push_back(f);
        end
      end
      if (mask != '0)
        fire_q[fire_q.size()-1].last = 1'b1;
    end else begin
      foreach (tick_fires[k])
        fire_q.push_back(tick_fires[k]);
    end
  endtask

  // fired-item checker: sampled before the edge updates, in arrival order
  always @(posedge clk) begin
    ptts_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (fire_q.size() == 0) begin
        $error("unexpected fired item: fired_slot %0d last %0d",
               out_item.fired_slot, out_item.last);
        errors++;
      end else begin
        want = fire_q.pop_front();
        if (out_item.fired_slot !== want.fired_slot) begin
          $error("fired_slot: expected %0d, got %0d", want.fired_slot, out_item.fired_slot);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  initial begin
    ptts_pkg::in_item_t cmd;
    int                 sent;

    for (int s = 0; s < ptts_pkg::TASK_SLOTS; s++) begin
      slot_on[s]   = 1'b0;
      slot_stat[s] = ptts_pkg::STAT_IDLE;
      slot_per[s]  = '0;
      slot_left[s] = '0;
    end
    sched_count = ptts_pkg::CNT_W'(ptts_pkg::TASK_SLOTS);

    // directed plan; firings are written out by hand only for the tick on the
    // empty table after reset and for commands that never fire, ticks on a
    // populated table go through the shadow
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 1, 8'h00);  // empty after reset
    add_row(ptts_pkg::OP_CREATE,  0, 16'h0000, 16'h0000, 1, 8'h00);  // period zero
    add_row(ptts_pkg::OP_CREATE,  7, 16'hFFFF, 16'hFFFF, 1, 8'h00);  // field maxima
    add_row(ptts_pkg::OP_CREATE,  1, 16'h0002, 16'h0001, 1, 8'h00);
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);  // slot 0 wraps
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);
    add_row(ptts_pkg::OP_CREATE,  2, 16'h0001, 16'h0000, 1, 8'h00);  // fires every tick
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);  // two firings
    add_row(ptts_pkg::OP_SUSPEND, 2, 16'h0000, 16'h0000, 1, 8'h00);
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);  // suspended holds
    add_row(ptts_pkg::OP_RESUME,  2, 16'h0000, 16'h0000, 1, 8'h00);
    add_row(ptts_pkg::OP_RESUME,  1, 16'h0000, 16'h0000, 1, 8'h00);  // resume of ready
    add_row(ptts_pkg::OP_SUSPEND, 5, 16'h0000, 16'h0000, 1, 8'h00);  // suspend of idle
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);
    add_row(OP_RSVD5,             7, 16'hFFFF, 16'hFFFF, 1, 8'h00);  // unused codes
    add_row(OP_RSVD7,             0, 16'hFFFF, 16'h0000, 1, 8'h00);
    add_row(ptts_pkg::OP_DELETE,  0, 16'h0000, 16'h0000, 1, 8'h00);  // shift all down
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);
    add_row(ptts_pkg::OP_DELETE,  7, 16'h0000, 16'h0000, 1, 8'h00);  // past the count
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);
    add_row(ptts_pkg::OP_CREATE,  3, 16'h0000, 16'h0002, 1, 8'h00);
    add_row(ptts_pkg::OP_TICK,    0, 16'h0000, 16'h0000, 0, 8'h00);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k])
      send_item(plan[k].cmd, plan[k].typed, plan[k].fire_mask);

    // random body: sender gaps switched on and off in blocks of items
    sent = 0;
    while (sent < MAIN_ITEMS) begin
      if (sent % 16 == 0)
        calm = ($urandom_range(0, 2) == 0);
      send_item(pick_command(1'b0), 1'b0, '0);
      sent++;
    end

    // closing stretch, back to back: enough deletes to empty the table
    // and keep deleting on an empty one
    calm = 1'b1;
    for (int k = 0; k < DRAIN_ITEMS; k++) begin
      cmd = pick_command(1'b1);
      if (k % 3 == 0)
        cmd.operation = ptts_pkg::OP_DELETE;
      send_item(cmd, 1'b0, '0);
    end
    start <= 1'b0;

    for (int w = 0; w < 100 && fire_q.size() != 0; w++)
      @(posedge clk);
    if (fire_q.size() != 0) begin
      $error("%0d fired items never came out", fire_q.size());
      errors++;
    end
    // longest tick plus its trailing item, with margin
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("periodic_task_tick_scheduler_tb OK");
    else
      $display("periodic_task_tick_scheduler_tb NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("periodic_task_tick_scheduler_tb NOT OK");
    $finish;
  end

endmodule
